// ===== rtl/fsp_pkg.sv =====
// ============================================================================
// fsp_pkg - format spec parser shared definitions
// Parse phases, control state, result word, character and code constants.
// ============================================================================
package fsp_pkg;

    // Parse phase, in the fixed order of the spec's optional parts
    typedef enum logic [3:0] {
        PH_START = 4'd0,
        PH_HELD  = 4'd1,
        PH_SIGN  = 4'd2,
        PH_ALT   = 4'd3,
        PH_ZERO  = 4'd4,
        PH_WIDTH = 4'd5,
        PH_GROUP = 4'd6,
        PH_DOT   = 4'd7,
        PH_TYPE  = 4'd8,
        PH_PNEED = 4'd9,
        PH_PIN   = 4'd10,
        PH_END   = 4'd11
    } phase_t;

    // Error codes
    localparam logic [3:0] ERR_NONE         = 4'd0;
    localparam logic [3:0] ERR_WIDTH_BIG    = 4'd1;
    localparam logic [3:0] ERR_NO_PREC      = 4'd2;
    localparam logic [3:0] ERR_PREC_BIG     = 4'd3;
    localparam logic [3:0] ERR_BAD_TYPE     = 4'd4;
    localparam logic [3:0] ERR_EXTRA_CHAR   = 4'd5;
    localparam logic [3:0] ERR_PREC_ON_INT  = 4'd6;
    localparam logic [3:0] ERR_COMMA_NONDEC = 4'd7;
    localparam logic [3:0] ERR_TEXT_FLAGS   = 4'd8;

    // Align codes
    localparam logic [2:0] ALIGN_NONE   = 3'd0;
    localparam logic [2:0] ALIGN_LEFT   = 3'd1;
    localparam logic [2:0] ALIGN_RIGHT  = 3'd2;
    localparam logic [2:0] ALIGN_CENTER = 3'd3;
    localparam logic [2:0] ALIGN_PAD    = 3'd4;

    // Sign codes
    localparam logic [1:0] SIGN_MINUS = 2'd0;
    localparam logic [1:0] SIGN_PLUS  = 2'd1;
    localparam logic [1:0] SIGN_SPACE = 2'd2;

    // Grouping codes
    localparam logic [1:0] GROUP_NONE  = 2'd0;
    localparam logic [1:0] GROUP_COMMA = 2'd1;
    localparam logic [1:0] GROUP_UNDER = 2'd2;

    // Type codes
    localparam logic [3:0] TYPE_NONE    = 4'd0;
    localparam logic [3:0] TYPE_DEC     = 4'd1;
    localparam logic [3:0] TYPE_BIN     = 4'd2;
    localparam logic [3:0] TYPE_OCT     = 4'd3;
    localparam logic [3:0] TYPE_HEX     = 4'd4;
    localparam logic [3:0] TYPE_HEX_UP  = 4'd5;
    localparam logic [3:0] TYPE_FIX     = 4'd6;
    localparam logic [3:0] TYPE_FIX_UP  = 4'd7;
    localparam logic [3:0] TYPE_EXP     = 4'd8;
    localparam logic [3:0] TYPE_EXP_UP  = 4'd9;
    localparam logic [3:0] TYPE_GEN     = 4'd10;
    localparam logic [3:0] TYPE_GEN_UP  = 4'd11;
    localparam logic [3:0] TYPE_PERCENT = 4'd12;
    localparam logic [3:0] TYPE_STR     = 4'd13;

    // Characters (21-bit code points)
    localparam logic [20:0] CH_SPACE = 21'h20;
    localparam logic [20:0] CH_HASH  = 21'h23;
    localparam logic [20:0] CH_PCT   = 21'h25;
    localparam logic [20:0] CH_PLUS  = 21'h2B;
    localparam logic [20:0] CH_COMMA = 21'h2C;
    localparam logic [20:0] CH_MINUS = 21'h2D;
    localparam logic [20:0] CH_DOT   = 21'h2E;
    localparam logic [20:0] CH_ZERO  = 21'h30;
    localparam logic [20:0] CH_NINE  = 21'h39;
    localparam logic [20:0] CH_LT    = 21'h3C;
    localparam logic [20:0] CH_EQ    = 21'h3D;
    localparam logic [20:0] CH_GT    = 21'h3E;
    localparam logic [20:0] CH_CARET = 21'h5E;
    localparam logic [20:0] CH_UNDER = 21'h5F;

    // Control state that the character step updates
    typedef struct packed {
        phase_t     phase;
        logic [3:0] error;
        logic [1:0] sign;
        logic       alt;
        logic       zpad;
        logic [1:0] grouping;
        logic       prec_given;
        logic [3:0] type_code;
    } fsp_ctl_t;

    localparam fsp_ctl_t CTL_RESET = '{
        phase:      PH_START,
        error:      ERR_NONE,
        sign:       SIGN_MINUS,
        alt:        1'b0,
        zpad:       1'b0,
        grouping:   GROUP_NONE,
        prec_given: 1'b0,
        type_code:  TYPE_NONE
    };

    // Result word
    typedef struct packed {
        logic [3:0]  error_code;
        logic [20:0] fill_char;
        logic [2:0]  align_mode;
        logic [1:0]  sign_mode;
        logic        alternate_form;
        logic        zero_pad;
        logic [12:0] field_width;
        logic [1:0]  grouping_mode;
        logic [7:0]  precision_value;
        logic [3:0]  type_code;
    } fsp_result_t;

    function automatic logic [2:0] align_of(input logic [20:0] ch);
        logic [2:0] code;
        case (ch)
            CH_LT:    code = ALIGN_LEFT;
            CH_GT:    code = ALIGN_RIGHT;
            CH_CARET: code = ALIGN_CENTER;
            CH_EQ:    code = ALIGN_PAD;
            default:  code = ALIGN_NONE;
        endcase
        return code;
    endfunction

    function automatic logic [3:0] type_of(input logic [20:0] ch);
        logic [3:0] code;
        case (ch)
            21'h64:  code = TYPE_DEC;
            21'h62:  code = TYPE_BIN;
            21'h6F:  code = TYPE_OCT;
            21'h78:  code = TYPE_HEX;
            21'h58:  code = TYPE_HEX_UP;
            21'h66:  code = TYPE_FIX;
            21'h46:  code = TYPE_FIX_UP;
            21'h65:  code = TYPE_EXP;
            21'h45:  code = TYPE_EXP_UP;
            21'h67:  code = TYPE_GEN;
            21'h47:  code = TYPE_GEN_UP;
            CH_PCT:  code = TYPE_PERCENT;
            21'h73:  code = TYPE_STR;
            default: code = TYPE_NONE;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/fsp_feed.sv =====
// ============================================================================
// fsp_feed - one character step of the spec parser
// Applies one character after fill/align to the control state, width and
// precision accumulators. Passes state through when off or after an error.
// ============================================================================
module fsp_feed #(
    parameter int WIDTH_LIMIT     = 4096,
    parameter int PRECISION_LIMIT = 100,
    parameter int WW = $clog2(WIDTH_LIMIT + 1),
    parameter int PW = ($clog2(PRECISION_LIMIT + 1) > 4) ? $clog2(PRECISION_LIMIT + 1) : 4
) (
    input  logic              en,
    input  logic [20:0]       ch,
    input  fsp_pkg::fsp_ctl_t ctl_in,
    input  logic [WW-1:0]     width_in,
    input  logic [PW-1:0]     prec_in,
    output fsp_pkg::fsp_ctl_t ctl_out,
    output logic [WW-1:0]     width_out,
    output logic [PW-1:0]     prec_out
);

    logic                is_dec;
    logic [3:0]          digit;
    logic [WW+3:0]       width_ten;
    logic [PW+3:0]       prec_ten;
    fsp_pkg::phase_t     cur_phase;
    logic                claimed;
    logic [3:0]          type_code;

    // Digit decode and the times-ten accumulators (shift-add)
    assign is_dec    = (ch >= fsp_pkg::CH_ZERO) && (ch <= fsp_pkg::CH_NINE);
    assign digit     = ch[3:0];
    assign width_ten = ({4'b0, width_in} << 3) + ({4'b0, width_in} << 1)
                     + {{WW{1'b0}}, digit};
    assign prec_ten  = ({4'b0, prec_in} << 3) + ({4'b0, prec_in} << 1)
                     + {{PW{1'b0}}, digit};
    assign type_code = fsp_pkg::type_of(ch);

    // Phase step: first matching optional part wins, else a type letter
    always_comb begin
        ctl_out   = ctl_in;
        width_out = width_in;
        prec_out  = prec_in;
        cur_phase = ctl_in.phase;
        claimed   = 1'b0;
        if (en && (ctl_in.error == fsp_pkg::ERR_NONE)) begin
            if (ctl_in.phase == fsp_pkg::PH_END) begin
                ctl_out.error = fsp_pkg::ERR_EXTRA_CHAR;
            end else if (ctl_in.phase == fsp_pkg::PH_PNEED) begin
                if (!is_dec) begin
                    ctl_out.error = fsp_pkg::ERR_NO_PREC;
                end else begin
                    prec_out           = PW'(digit);
                    ctl_out.prec_given = 1'b1;
                    ctl_out.phase      = fsp_pkg::PH_PIN;
                end
            end else begin
                // precision digits continue; anything else ends them
                if (cur_phase == fsp_pkg::PH_PIN) begin
                    if (is_dec) begin
                        claimed  = 1'b1;
                        prec_out = prec_ten[PW-1:0];
                        if (prec_ten > (PW+4)'(PRECISION_LIMIT)) begin
                            ctl_out.error = fsp_pkg::ERR_PREC_BIG;
                        end
                    end else begin
                        cur_phase = fsp_pkg::PH_TYPE;
                    end
                end
                if (!claimed) begin
                    if ((cur_phase <= fsp_pkg::PH_SIGN) &&
                        ((ch == fsp_pkg::CH_PLUS) || (ch == fsp_pkg::CH_MINUS) ||
                         (ch == fsp_pkg::CH_SPACE))) begin
                        ctl_out.sign  = (ch == fsp_pkg::CH_PLUS)  ? fsp_pkg::SIGN_PLUS :
                                        (ch == fsp_pkg::CH_SPACE) ? fsp_pkg::SIGN_SPACE :
                                                                    fsp_pkg::SIGN_MINUS;
                        ctl_out.phase = fsp_pkg::PH_ALT;
                    end else if ((cur_phase <= fsp_pkg::PH_ALT) &&
                                 (ch == fsp_pkg::CH_HASH)) begin
                        ctl_out.alt   = 1'b1;
                        ctl_out.phase = fsp_pkg::PH_ZERO;
                    end else if ((cur_phase <= fsp_pkg::PH_ZERO) &&
                                 (ch == fsp_pkg::CH_ZERO)) begin
                        ctl_out.zpad  = 1'b1;
                        ctl_out.phase = fsp_pkg::PH_WIDTH;
                    end else if ((cur_phase <= fsp_pkg::PH_WIDTH) && is_dec) begin
                        width_out     = width_ten[WW-1:0];
                        ctl_out.phase = fsp_pkg::PH_WIDTH;
                        if (width_ten > (WW+4)'(WIDTH_LIMIT)) begin
                            ctl_out.error = fsp_pkg::ERR_WIDTH_BIG;
                        end
                    end else if ((cur_phase <= fsp_pkg::PH_GROUP) &&
                                 ((ch == fsp_pkg::CH_COMMA) ||
                                  (ch == fsp_pkg::CH_UNDER))) begin
                        ctl_out.grouping = (ch == fsp_pkg::CH_COMMA) ?
                                           fsp_pkg::GROUP_COMMA : fsp_pkg::GROUP_UNDER;
                        ctl_out.phase    = fsp_pkg::PH_DOT;
                    end else if ((cur_phase <= fsp_pkg::PH_DOT) &&
                                 (ch == fsp_pkg::CH_DOT)) begin
                        ctl_out.phase = fsp_pkg::PH_PNEED;
                    end else begin
                        ctl_out.type_code = type_code;
                        ctl_out.phase     = fsp_pkg::PH_END;
                        if (type_code == fsp_pkg::TYPE_NONE) begin
                            ctl_out.error = fsp_pkg::ERR_BAD_TYPE;
                        end
                    end
                end
            end
        end
    end

endmodule

// ===== rtl/format_spec_parser_top.sv =====
// ============================================================================
// format_spec_parser_top - format spec mini-language parser
// Takes at most one spec char per word, keeps the parse state, and on the last
// word of a spec delivers one result word with the fields or an error code.
// ============================================================================
// Throughput: one input word per cycle, sustained, while results are taken.
// Result: m_valid rises in the cycle after the last word is accepted,
//   loaded from the single result register.
// Non-last words never wait on the result side beyond a full output register.
// Reset: aresetn low clears the parse state to start and drops m_valid.
// ----------------------------------------------------------------------------
module format_spec_parser_top #(
    parameter int WIDTH_LIMIT     = 4096,
    parameter int PRECISION_LIMIT = 100
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [20:0] s_char_code,
    input  logic        s_has_char,
    input  logic        s_last,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_error_code,
    output logic [20:0] m_fill_char,
    output logic [2:0]  m_align_mode,
    output logic [1:0]  m_sign_mode,
    output logic        m_alternate_form,
    output logic        m_zero_pad,
    output logic [12:0] m_field_width,
    output logic [1:0]  m_grouping_mode,
    output logic [7:0]  m_precision_value,
    output logic [3:0]  m_type_code
);

    localparam int WW = $clog2(WIDTH_LIMIT + 1);
    localparam int PW = ($clog2(PRECISION_LIMIT + 1) > 4) ? $clog2(PRECISION_LIMIT + 1) : 4;

    // Parse state
    fsp_pkg::fsp_ctl_t  ctl_reg, ctl_next;
    logic [WW-1:0]      width_reg, width_next;
    logic [PW-1:0]      prec_reg, prec_next;
    logic [20:0]        fill_reg, fill_next;
    logic [2:0]         align_reg, align_next;
    logic [20:0]        held_char_reg, held_char_next;

    // Result register
    logic                 m_valid_reg, m_valid_next;
    fsp_pkg::fsp_result_t res_reg, res_next;

    // Step signals
    logic               accept;
    logic               start_has;
    logic               in_held;
    logic               second;
    logic               resolve;
    logic [20:0]        hchar;
    logic [2:0]         c_align;
    logic [2:0]         h_align;
    logic               feed_a_en, feed_b_en;
    fsp_pkg::fsp_ctl_t  pre_ctl, mid_ctl, post_ctl, step_ctl;
    logic [WW-1:0]      mid_width, step_width;
    logic [PW-1:0]      mid_prec, step_prec;
    logic [20:0]        fill_step;
    logic [2:0]         align_step;
    logic [3:0]         fin_err;
    logic               int_type, nondec_type;

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;

    // Held first character: resolved as fill+align, bare align, or plain chars
    assign start_has = (ctl_reg.phase == fsp_pkg::PH_START) && s_has_char &&
                       (ctl_reg.error == fsp_pkg::ERR_NONE);
    assign in_held   = (ctl_reg.phase == fsp_pkg::PH_HELD);
    assign second    = in_held && s_has_char;
    assign resolve   = (in_held && (s_has_char || s_last)) || (start_has && s_last);
    assign hchar     = in_held ? held_char_reg : s_char_code;
    assign c_align   = fsp_pkg::align_of(s_char_code);
    assign h_align   = fsp_pkg::align_of(hchar);

    always_comb begin
        pre_ctl    = ctl_reg;
        fill_step  = fill_reg;
        align_step = align_reg;
        feed_a_en  = 1'b0;
        feed_b_en  = 1'b0;
        if (resolve) begin
            pre_ctl.phase = fsp_pkg::PH_SIGN;
            if (second && (c_align != fsp_pkg::ALIGN_NONE)) begin
                fill_step  = hchar;
                align_step = c_align;
            end else if (h_align != fsp_pkg::ALIGN_NONE) begin
                align_step = h_align;
                feed_b_en  = second;
            end else begin
                feed_a_en = 1'b1;
                feed_b_en = second;
            end
        end else if (s_has_char && (ctl_reg.phase != fsp_pkg::PH_START) &&
                     (ctl_reg.phase != fsp_pkg::PH_HELD)) begin
            feed_b_en = 1'b1;
        end
    end

    // Two chained character steps: held char, then the new char
    fsp_feed #(
        .WIDTH_LIMIT     (WIDTH_LIMIT),
        .PRECISION_LIMIT (PRECISION_LIMIT),
        .WW              (WW),
        .PW              (PW)
    ) u_feed_a (
        .en        (feed_a_en),
        .ch        (hchar),
        .ctl_in    (pre_ctl),
        .width_in  (width_reg),
        .prec_in   (prec_reg),
        .ctl_out   (mid_ctl),
        .width_out (mid_width),
        .prec_out  (mid_prec)
    );

    fsp_feed #(
        .WIDTH_LIMIT     (WIDTH_LIMIT),
        .PRECISION_LIMIT (PRECISION_LIMIT),
        .WW              (WW),
        .PW              (PW)
    ) u_feed_b (
        .en        (feed_b_en),
        .ch        (s_char_code),
        .ctl_in    (mid_ctl),
        .width_in  (mid_width),
        .prec_in   (mid_prec),
        .ctl_out   (post_ctl),
        .width_out (step_width),
        .prec_out  (step_prec)
    );

    // First character of a spec that goes on is held back
    always_comb begin
        step_ctl = post_ctl;
        if (start_has && !s_last) begin
            step_ctl.phase = fsp_pkg::PH_HELD;
        end
    end

    // End-of-spec consistency checks, first error wins
    assign int_type    = (step_ctl.type_code >= fsp_pkg::TYPE_DEC) &&
                         (step_ctl.type_code <= fsp_pkg::TYPE_HEX_UP);
    assign nondec_type = (step_ctl.type_code >= fsp_pkg::TYPE_BIN) &&
                         (step_ctl.type_code <= fsp_pkg::TYPE_HEX_UP);

    always_comb begin
        fin_err = step_ctl.error;
        if (fin_err == fsp_pkg::ERR_NONE) begin
            if (step_ctl.phase == fsp_pkg::PH_PNEED) begin
                fin_err = fsp_pkg::ERR_NO_PREC;
            end else if (step_ctl.prec_given && int_type) begin
                fin_err = fsp_pkg::ERR_PREC_ON_INT;
            end else if ((step_ctl.grouping == fsp_pkg::GROUP_COMMA) && nondec_type) begin
                fin_err = fsp_pkg::ERR_COMMA_NONDEC;
            end else if ((step_ctl.type_code == fsp_pkg::TYPE_STR) &&
                         ((step_ctl.sign != fsp_pkg::SIGN_MINUS) || step_ctl.alt ||
                          (step_ctl.grouping != fsp_pkg::GROUP_NONE))) begin
                fin_err = fsp_pkg::ERR_TEXT_FLAGS;
            end
        end
    end

    // Result word: fields on success, reset values with an error
    always_comb begin
        res_next.error_code = fin_err;
        if (fin_err == fsp_pkg::ERR_NONE) begin
            res_next.fill_char       = fill_step;
            res_next.align_mode      = align_step;
            res_next.sign_mode       = step_ctl.sign;
            res_next.alternate_form  = step_ctl.alt;
            res_next.zero_pad        = step_ctl.zpad;
            res_next.field_width     = 13'(step_width);
            res_next.grouping_mode   = step_ctl.grouping;
            res_next.precision_value = step_ctl.prec_given ? 8'(step_prec) : 8'hFF;
            res_next.type_code       = step_ctl.type_code;
        end else begin
            res_next.fill_char       = fsp_pkg::CH_SPACE;
            res_next.align_mode      = fsp_pkg::ALIGN_NONE;
            res_next.sign_mode       = fsp_pkg::SIGN_MINUS;
            res_next.alternate_form  = 1'b0;
            res_next.zero_pad        = 1'b0;
            res_next.field_width     = 13'd0;
            res_next.grouping_mode   = fsp_pkg::GROUP_NONE;
            res_next.precision_value = 8'hFF;
            res_next.type_code       = fsp_pkg::TYPE_NONE;
        end
    end

    // Next state: advance on accept, back to start after the last word
    always_comb begin
        ctl_next       = ctl_reg;
        width_next     = width_reg;
        prec_next      = prec_reg;
        fill_next      = fill_reg;
        align_next     = align_reg;
        held_char_next = held_char_reg;
        if (accept) begin
            if (s_last) begin
                ctl_next       = fsp_pkg::CTL_RESET;
                width_next     = '0;
                prec_next      = '0;
                fill_next      = fsp_pkg::CH_SPACE;
                align_next     = fsp_pkg::ALIGN_NONE;
                held_char_next = '0;
            end else begin
                ctl_next   = step_ctl;
                width_next = step_width;
                prec_next  = step_prec;
                fill_next  = fill_step;
                align_next = align_step;
                if (start_has) begin
                    held_char_next = s_char_code;
                end
            end
        end
    end

    always_comb begin
        if (accept && s_last) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg       <= fsp_pkg::CTL_RESET;
            width_reg     <= '0;
            prec_reg      <= '0;
            fill_reg      <= fsp_pkg::CH_SPACE;
            align_reg     <= fsp_pkg::ALIGN_NONE;
            held_char_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            ctl_reg       <= ctl_next;
            width_reg     <= width_next;
            prec_reg      <= prec_next;
            fill_reg      <= fill_next;
            align_reg     <= align_next;
            held_char_reg <= held_char_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Result payload loads only with a new result
    always_ff @(posedge aclk) begin
        if (accept && s_last) begin
            res_reg <= res_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_error_code      = res_reg.error_code;
    assign m_fill_char       = res_reg.fill_char;
    assign m_align_mode      = res_reg.align_mode;
    assign m_sign_mode       = res_reg.sign_mode;
    assign m_alternate_form  = res_reg.alternate_form;
    assign m_zero_pad        = res_reg.zero_pad;
    assign m_field_width     = res_reg.field_width;
    assign m_grouping_mode   = res_reg.grouping_mode;
    assign m_precision_value = res_reg.precision_value;
    assign m_type_code       = res_reg.type_code;

    // Checks
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_last |=> m_valid)
        else $error("last word accepted without a result");

    a_no_invented_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && accept && !s_last |=> !m_valid)
        else $error("result raised by a non-last word");

    a_error_clears_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_error_code != fsp_pkg::ERR_NONE) |->
            (m_fill_char == fsp_pkg::CH_SPACE) && (m_field_width == 13'd0) &&
            (m_precision_value == 8'hFF) && (m_type_code == fsp_pkg::TYPE_NONE))
        else $error("error result carries field values");

    a_text_no_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_error_code == fsp_pkg::ERR_NONE) &&
        (m_type_code == fsp_pkg::TYPE_STR) |->
            (m_sign_mode == fsp_pkg::SIGN_MINUS) && !m_alternate_form &&
            (m_grouping_mode == fsp_pkg::GROUP_NONE))
        else $error("text type accepted with numeric flags");

    a_state_back_to_start: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_last |=> (ctl_reg.phase == fsp_pkg::PH_START) &&
            (ctl_reg.error == fsp_pkg::ERR_NONE))
        else $error("parse state not cleared after last word");

endmodule
